/* rtl/mjp_pkg.sv */
// Shared types, codes and saturation helpers for the multi-joint PID block.
// No dependencies; imported by every other file of the block.
`default_nettype none

package mjp_pkg;

  localparam int WORD_W    = 32;
  localparam int INTEG_W   = 48;
  localparam int NUM_WORDS = 5;   // gain words per joint

  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic signed [INTEG_W-1:0] integ_t;
  typedef logic signed [63:0]        prod_t;

  localparam word_t  WORD_MAX  = 32'sh7FFF_FFFF;
  localparam word_t  WORD_MIN  = 32'sh8000_0000;
  localparam integ_t INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam integ_t INTEG_MIN = 48'sh8000_0000_0000;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    SEL_KP   = 3'd0,
    SEL_KD   = 3'd1,
    SEL_KI   = 3'd2,
    SEL_PLIM = 3'd3,
    SEL_VLIM = 3'd4
  } sel_t;

  typedef struct packed {
    word_t kp;
    word_t kd;
    word_t ki;
    word_t plim;
    word_t vlim;
  } gains_t;

  typedef struct packed {
    word_t pos_err;
    word_t vel_err;
    logic  err_clamped;
  } err_t;

  // 34-bit value saturated into the signed 32-bit range
  function automatic word_t sat_word(input logic signed [33:0] x);
    word_t r;
    if (!x[33] && (x[32:31] != 2'b00)) begin
      r = WORD_MAX;
    end else if (x[33] && (x[32:31] != 2'b11)) begin
      r = WORD_MIN;
    end else begin
      r = word_t'(x[31:0]);
    end
    return r;
  endfunction

  // 49-bit value saturated into the signed 48-bit range
  function automatic integ_t sat_integ(input logic signed [INTEG_W:0] x);
    integ_t r;
    if (x[INTEG_W] != x[INTEG_W-1]) begin
      r = x[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      r = integ_t'(x[INTEG_W-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/mjp_in_if.sv */
// Input channel: valid/ready handshake carrying one load or control-step item.
// Depends on mjp_pkg for the Q16.16 word type.
`default_nettype none

interface mjp_in_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [3:0]          joint_index;
  logic [2:0]          word_select;
  mjp_pkg::word_t      load_value;
  mjp_pkg::word_t      pos_desired;
  mjp_pkg::word_t      pos_measured;
  mjp_pkg::word_t      vel_desired;
  mjp_pkg::word_t      vel_measured;
  logic                clear_integral;

  modport source (
    output valid, opcode, joint_index, word_select, load_value,
           pos_desired, pos_measured, vel_desired, vel_measured, clear_integral,
    input  ready
  );

  modport sink (
    input  valid, opcode, joint_index, word_select, load_value,
           pos_desired, pos_measured, vel_desired, vel_measured, clear_integral,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/mjp_out_if.sv */
// Result channel: valid/ready handshake carrying one torque result.
// Depends on mjp_pkg for the word and integral types.
`default_nettype none

interface mjp_out_if;
  logic             valid;
  logic             ready;
  mjp_pkg::word_t   torque;
  mjp_pkg::word_t   pos_error;
  mjp_pkg::word_t   vel_error;
  mjp_pkg::integ_t  integral_value;
  logic             error_clamped;
  logic             torque_saturated;

  modport source (
    output valid, torque, pos_error, vel_error, integral_value,
           error_clamped, torque_saturated,
    input  ready
  );

  modport sink (
    input  valid, torque, pos_error, vel_error, integral_value,
           error_clamped, torque_saturated,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/mjp_gain_mem.sv */
// One gain word per joint: simple dual-port RAM with registered read.
// Depends on mjp_pkg.
`default_nettype none

module mjp_gain_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mjp_pkg::word_t      wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output mjp_pkg::word_t      rdata
);
  import mjp_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

/* rtl/mjp_integ_store.sv */
// Per-joint integral RAM with valid bits (unwritten reads as zero) and
// write-to-read bypass for back-to-back steps on one joint. Depends on mjp_pkg.
`default_nettype none

module mjp_integ_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mjp_pkg::integ_t     wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output mjp_pkg::integ_t     rdata
);
  import mjp_pkg::*;

  integ_t           mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic             bypass;

  assign bypass = we && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (bypass) begin
        rdata <= wdata;
      end else if (vld[raddr]) begin
        rdata <= mem[raddr];
      end else begin
        rdata <= '0;
      end
    end
  end
endmodule

`default_nettype wire

/* rtl/mjp_clamp_stage.sv */
// Error stage: clamps position error and desired velocity to the joint limits,
// forms the velocity error, saturates both to 32 bits. Depends on mjp_pkg.
`default_nettype none

module mjp_clamp_stage (
  input  logic              clk,
  input  logic              en,
  input  mjp_pkg::gains_t   gains,
  input  mjp_pkg::word_t    pos_desired,
  input  mjp_pkg::word_t    pos_measured,
  input  mjp_pkg::word_t    vel_desired,
  input  mjp_pkg::word_t    vel_measured,
  output mjp_pkg::err_t     err
);
  import mjp_pkg::*;

  logic signed [33:0] pdiff, plim_p, plim_n, pclamp;
  logic signed [33:0] vdes, vlim_p, vlim_n, vclamp, vdiff;
  logic               phit;
  err_t               err_next;

  always_comb begin
    pdiff  = 34'(pos_desired) - 34'(pos_measured);
    plim_p = 34'(gains.plim);
    plim_n = -plim_p;
    phit   = 1'b1;
    if (pdiff > plim_p) begin
      pclamp = plim_p;
    end else if (pdiff < plim_n) begin
      pclamp = plim_n;
    end else begin
      pclamp = pdiff;
      phit   = 1'b0;
    end

    vdes   = 34'(vel_desired);
    vlim_p = 34'(gains.vlim);
    vlim_n = -vlim_p;
    if (vdes > vlim_p) begin
      vclamp = vlim_p;
    end else if (vdes < vlim_n) begin
      vclamp = vlim_n;
    end else begin
      vclamp = vdes;
    end
    vdiff = vclamp - 34'(vel_measured);

    err_next.pos_err     = sat_word(pclamp);
    err_next.vel_err     = sat_word(vdiff);
    err_next.err_clamped = phit;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err <= err_next;
    end
  end
endmodule

`default_nettype wire

/* rtl/mjp_torque_stage.sv */
// Torque stages: ki times the integral split at bit 16, partial sum of the
// floored kp and kd terms, then the exact sum saturated to 32 bits.
// Depends on mjp_pkg.
`default_nettype none

module mjp_torque_stage (
  input  logic              clk,
  input  logic              en_mul,
  input  logic              en_sum,
  input  mjp_pkg::word_t    ki,
  input  mjp_pkg::integ_t   integ,
  input  mjp_pkg::prod_t    prod_kp,
  input  mjp_pkg::prod_t    prod_kd,
  output mjp_pkg::word_t    torque,
  output logic              torque_sat
);
  import mjp_pkg::*;

  word_t              integ_hi;
  logic [15:0]        integ_lo;
  prod_t              ki_hi_next, ki_hi;
  logic signed [48:0] ki_lo_next, ki_lo;
  logic signed [48:0] psum_next, psum;
  logic signed [64:0] total;
  word_t              torque_next;
  logic               sat_next;

  // integral = hi*2^16 + lo with lo unsigned, so the ki term floors exactly
  assign integ_hi   = word_t'(integ[INTEG_W-1:16]);
  assign integ_lo   = integ[15:0];
  assign ki_hi_next = prod_t'(ki) * prod_t'(integ_hi);
  assign ki_lo_next = 49'(ki) * $signed({1'b0, integ_lo});
  assign psum_next  = 49'(48'(prod_kp >>> 16)) + 49'(48'(prod_kd >>> 16));

  always_ff @(posedge clk) begin
    if (en_mul) begin
      ki_hi <= ki_hi_next;
      ki_lo <= ki_lo_next;
      psum  <= psum_next;
    end
  end

  always_comb begin
    total = 65'(ki_hi) + 65'(psum) + 65'(ki_lo >>> 16);
    if (!total[64] && (|total[63:31])) begin
      torque_next = WORD_MAX;
      sat_next    = 1'b1;
    end else if (total[64] && !(&total[63:31])) begin
      torque_next = WORD_MIN;
      sat_next    = 1'b1;
    end else begin
      torque_next = word_t'(total[31:0]);
      sat_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      torque     <= torque_next;
      torque_sat <= sat_next;
    end
  end
endmodule

`default_nettype wire

/* rtl/multi_joint_position_pid.sv */
// Time-shared PID torque controller, one control step per joint per transfer.
// A step's result is valid once it has passed s1, s2, s3, s4 and out.
// Five-stage valid/ready pipeline; one item per cycle unless result stalls it.
// Loads write the gain RAMs at the transfer edge and produce no result.
// Reset (rst, synchronous) empties the pipeline and zeroes all joint integrals
// through per-joint valid bits; gain words stay undefined until loaded.
`default_nettype none

module multi_joint_position_pid #(
  parameter int NUM_JOINTS = 16
) (
  input  logic     clk,
  input  logic     rst,
  mjp_in_if.sink   item,
  mjp_out_if.source result
);
  import mjp_pkg::*;

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // ---------------------------------------------------------------------
  // Pipeline occupancy and per-stage handshake.
  // s1: gain RAM read data + step operands
  // s2: clamped errors + integral read data
  // s3: updated integral + kp/kd products
  // s4: ki products + partial sum (inside the torque stage)
  // out: result register
  // ---------------------------------------------------------------------
  logic s1_v, s2_v, s3_v, s4_v, out_v;
  logic s1_adv, s2_adv, s3_adv, s4_adv;
  logic s1_free, s2_free, s3_free, s4_free, out_free;

  assign out_free = !out_v || result.ready;
  assign s4_adv   = s4_v && out_free;
  assign s4_free  = !s4_v || s4_adv;
  assign s3_adv   = s3_v && s4_free;
  assign s3_free  = !s3_v || s3_adv;
  assign s2_adv   = s2_v && s3_free;
  assign s2_free  = !s2_v || s2_adv;
  assign s1_adv   = s1_v && s2_free;
  assign s1_free  = !s1_v || s1_adv;

  assign item.ready = s1_free;

  // ---------------------------------------------------------------------
  // Input decode. Out-of-range joints and bad word selects are dropped.
  // ---------------------------------------------------------------------
  logic          acc, in_range, step_acc, load_acc, sel_ok;
  logic [JW-1:0] acc_joint;

  assign acc       = item.valid && item.ready;
  assign in_range  = 32'(item.joint_index) < NUM_JOINTS;
  assign sel_ok    = item.word_select < 3'(NUM_WORDS);
  assign acc_joint = JW'(item.joint_index);
  assign step_acc  = acc && in_range && (op_t'(item.opcode) == OP_STEP);
  assign load_acc  = acc && in_range && (op_t'(item.opcode) == OP_LOAD) && sel_ok;

  // Gain table: one RAM per word select, all read together on a step.
  word_t  gain_rd [NUM_WORDS];
  gains_t s1_gains;

  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_gain
    mjp_gain_mem #(
      .DEPTH (NUM_JOINTS),
      .AW    (JW)
    ) u_mem (
      .clk   (clk),
      .we    (load_acc && (item.word_select == 3'(w))),
      .waddr (acc_joint),
      .wdata (item.load_value),
      .re    (step_acc),
      .raddr (acc_joint),
      .rdata (gain_rd[w])
    );
  end

  assign s1_gains.kp   = gain_rd[SEL_KP];
  assign s1_gains.kd   = gain_rd[SEL_KD];
  assign s1_gains.ki   = gain_rd[SEL_KI];
  assign s1_gains.plim = gain_rd[SEL_PLIM];
  assign s1_gains.vlim = gain_rd[SEL_VLIM];

  // ---------------------------------------------------------------------
  // Stage 1 operands
  // ---------------------------------------------------------------------
  word_t         s1_pd, s1_pm, s1_vd, s1_vm;
  logic          s1_clear;
  logic [JW-1:0] s1_joint;

  always_ff @(posedge clk) begin
    if (step_acc) begin
      s1_pd    <= item.pos_desired;
      s1_pm    <= item.pos_measured;
      s1_vd    <= item.vel_desired;
      s1_vm    <= item.vel_measured;
      s1_clear <= item.clear_integral;
      s1_joint <= acc_joint;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: clamped errors; integral for this joint read in parallel
  // ---------------------------------------------------------------------
  err_t          s2_err;
  word_t         s2_kp, s2_kd, s2_ki;
  logic          s2_clear;
  logic [JW-1:0] s2_joint;
  integ_t        s2_integ_old;
  integ_t        integ_next;

  mjp_clamp_stage u_clamp (
    .clk          (clk),
    .en           (s1_adv),
    .gains        (s1_gains),
    .pos_desired  (s1_pd),
    .pos_measured (s1_pm),
    .vel_desired  (s1_vd),
    .vel_measured (s1_vm),
    .err          (s2_err)
  );

  // Write-back happens as stage 2 moves on; the store bypasses that value
  // when the step right behind it targets the same joint.
  mjp_integ_store #(
    .DEPTH (NUM_JOINTS),
    .AW    (JW)
  ) u_integ (
    .clk   (clk),
    .rst   (rst),
    .we    (s2_adv),
    .waddr (s2_joint),
    .wdata (integ_next),
    .re    (s1_adv),
    .raddr (s1_joint),
    .rdata (s2_integ_old)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_kp    <= s1_gains.kp;
      s2_kd    <= s1_gains.kd;
      s2_ki    <= s1_gains.ki;
      s2_clear <= s1_clear;
      s2_joint <= s1_joint;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: saturating integral update, kp and kd products
  // ---------------------------------------------------------------------
  integ_t s3_integ;
  prod_t  s3_pkp, s3_pkd;
  word_t  s3_ki;
  err_t   s3_err;

  always_comb begin
    if (s2_clear) begin
      integ_next = '0;
    end else begin
      integ_next = sat_integ(49'(s2_integ_old) + 49'(s2_err.pos_err));
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_integ <= integ_next;
      s3_pkp   <= prod_t'(s2_kp) * prod_t'(s2_err.pos_err);
      s3_pkd   <= prod_t'(s2_kd) * prod_t'(s2_err.vel_err);
      s3_ki    <= s2_ki;
      s3_err   <= s2_err;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 4 and out: ki products, then exact sum with saturation
  // ---------------------------------------------------------------------
  integ_t s4_integ, out_integ;
  err_t   s4_err, out_err;
  word_t  out_torque;
  logic   out_tsat;

  mjp_torque_stage u_torque (
    .clk        (clk),
    .en_mul     (s3_adv),
    .en_sum     (s4_adv),
    .ki         (s3_ki),
    .integ      (s3_integ),
    .prod_kp    (s3_pkp),
    .prod_kd    (s3_pkd),
    .torque     (out_torque),
    .torque_sat (out_tsat)
  );

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s4_integ <= s3_integ;
      s4_err   <= s3_err;
    end
    if (s4_adv) begin
      out_integ <= s4_integ;
      out_err   <= s4_err;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v <= step_acc;
      end
      if (s2_free) begin
        s2_v <= s1_adv;
      end
      if (s3_free) begin
        s3_v <= s2_adv;
      end
      if (s4_free) begin
        s4_v <= s3_adv;
      end
      if (out_free) begin
        out_v <= s4_adv;
      end
    end
  end

  assign result.valid            = out_v;
  assign result.torque           = out_torque;
  assign result.pos_error        = out_err.pos_err;
  assign result.vel_error        = out_err.vel_err;
  assign result.integral_value   = out_integ;
  assign result.error_clamped    = out_err.err_clamped;
  assign result.torque_saturated = out_tsat;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (acc && (op_t'(item.opcode) == OP_LOAD)) |=> !s1_v)
    else $error("load transfer entered the step pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_v && !s1_adv) |=> s1_v)
    else $error("stalled stage 1 item lost");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (s2_adv && s2_clear) |=> (s3_integ == '0))
    else $error("cleared integral not zero");

  a_tsat_rail: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_tsat) |-> ((out_torque == WORD_MAX) || (out_torque == WORD_MIN)))
    else $error("saturated torque not at a rail");

endmodule

`default_nettype wire
